// ----- rtl/imurcf_pkg.sv -----
// ----------------------------------------------------------------------------
// imurcf_pkg
// Shared widths, constants, CORDIC angle table and controller-to-datapath
// command type for the roll complementary filter.
// ----------------------------------------------------------------------------
package imurcf_pkg;

  // CORDIC iteration count and table size
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_LEN     = 24;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int ATAN_IDX_W   = $clog2(ATAN_LEN);

  // Field widths
  localparam int IN_W     = 16;
  localparam int TEMP_W   = 17;
  localparam int RATE_W   = 16;
  localparam int ROLL_W   = 18;
  localparam int WGT_W    = 16;
  localparam int IN_DATA_W  = 6 * IN_W;
  localparam int OUT_FLD_W  = TEMP_W + 3 * RATE_W + ROLL_W;
  localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

  // Internal widths
  localparam int CORD_W = 27;   // CORDIC x, y and angle
  localparam int PRED_W = 19;   // predicted roll
  localparam int TILT_W = 18;   // accelerometer tilt, 1/256 degree
  localparam int MUL_W  = 25;   // shared multiplier operand width
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = 37;   // blend accumulator
  localparam int MAG_W  = MUL_W - 1;
  localparam int GXQ_W  = 10;   // gyro roll increment magnitude
  localparam int FRAC_W = 16;   // weight fraction bits

  // Configuration and filter constants
  localparam logic [WGT_W-1:0] WEIGHT_RESET = 16'd64225;
  localparam int ROLL_LIMIT   = 92160;
  localparam int TEMP_OFFSET  = 12412;
  localparam int ANG_HALF_TURN = 180 * 65536;
  localparam int TILT_ROUND   = 128;
  localparam int TILT_SHIFT   = 8;
  localparam int BLEND_ROUND  = 32768;

  // Constant divisors as reciprocal multiply, exact over the operand range
  localparam int TEMP_RECIP = 12632257;  // ceil(2^30 / 85)
  localparam int TEMP_HALF  = 42;
  localparam int TEMP_SHIFT = 30;
  localparam int RATE_RECIP = 8196503;   // ceil(2^30 / 131)
  localparam int RATE_HALF  = 65;
  localparam int RATE_SHIFT = 30;
  localparam int GX_RECIP   = 1311441;   // ceil(2^32 / 3275)
  localparam int GX_HALF    = 1637;
  localparam int GX_SHIFT   = 32;

  // Multiplier operations, first five issued in step order
  typedef enum logic [2:0] {
    MUL_TEMP,
    MUL_RX,
    MUL_RY,
    MUL_RZ,
    MUL_GX,
    MUL_WP,
    MUL_WT
  } mul_op_e;

  typedef struct packed {
    logic              ld_in;
    logic              cordic_step;
    logic [STEP_W-1:0] step_idx;
    logic              mul_en;
    mul_op_e           mul_op;
    logic              tilt_ld;
    logic              result_ld;
  } dp_cmd_t;

  // atan(2^-i) in 1/65536 degree
  function automatic logic signed [CORD_W-1:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [CORD_W-1:0] val;
    case (idx)
      5'd0:    val = 27'sd2949120;
      5'd1:    val = 27'sd1740967;
      5'd2:    val = 27'sd919879;
      5'd3:    val = 27'sd466945;
      5'd4:    val = 27'sd234379;
      5'd5:    val = 27'sd117304;
      5'd6:    val = 27'sd58666;
      5'd7:    val = 27'sd29335;
      5'd8:    val = 27'sd14668;
      5'd9:    val = 27'sd7334;
      5'd10:   val = 27'sd3667;
      5'd11:   val = 27'sd1833;
      5'd12:   val = 27'sd917;
      5'd13:   val = 27'sd458;
      5'd14:   val = 27'sd229;
      5'd15:   val = 27'sd115;
      5'd16:   val = 27'sd57;
      5'd17:   val = 27'sd29;
      5'd18:   val = 27'sd14;
      5'd19:   val = 27'sd7;
      5'd20:   val = 27'sd4;
      5'd21:   val = 27'sd2;
      5'd22:   val = 27'sd1;
      default: val = 27'sd0;
    endcase
    return val;
  endfunction

endpackage

// ----- rtl/imu_roll_complementary_filter_core.sv -----
// The iterative CORDIC takes one micro-rotation per cycle and is followed by tilt
// rounding, two blend products, accumulate and result load; the result load waits
// while an earlier result is still held, and the input is not ready again until
// the controller has loaded the result and returned to its idle state.
// A waiting result stays in the output register while the next sample is accepted.
// Reset: asynchronous, active low; clears roll state to zero and filter_weight to 64225.
// ----------------------------------------------------------------------------
// imu_roll_complementary_filter_core
// Converts one raw inertial sample to temperature, angular rates and a fused
// roll angle from a complementary filter over gyro and accelerometer tilt.
// ----------------------------------------------------------------------------
module imu_roll_complementary_filter_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [imurcf_pkg::WGT_W-1:0]        cfg_wdata_i,     // filter_weight
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // accel_y, accel_z, temp_raw, gyro_x, gyro_y, gyro_z (16 bits each)
  input  logic [imurcf_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // temperature[16:0], rate_x[32:17], rate_y[48:33], rate_z[64:49],
  // roll_angle[82:65], zero fill above
  output logic [imurcf_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
  import imurcf_pkg::*;

  dp_cmd_t                  cmd;
  logic signed [TEMP_W-1:0] temperature;
  logic signed [RATE_W-1:0] rate_x, rate_y, rate_z;
  logic signed [ROLL_W-1:0] roll_angle;

  imurcf_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd_o         (cmd)
  );

  imurcf_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .accel_y_i     ($signed(s_axis_tdata[0*IN_W +: IN_W])),
    .accel_z_i     ($signed(s_axis_tdata[1*IN_W +: IN_W])),
    .temp_raw_i    ($signed(s_axis_tdata[2*IN_W +: IN_W])),
    .gyro_x_i      ($signed(s_axis_tdata[3*IN_W +: IN_W])),
    .gyro_y_i      ($signed(s_axis_tdata[4*IN_W +: IN_W])),
    .gyro_z_i      ($signed(s_axis_tdata[5*IN_W +: IN_W])),
    .cmd_i         (cmd),
    .temperature_o (temperature),
    .rate_x_o      (rate_x),
    .rate_y_o      (rate_y),
    .rate_z_o      (rate_z),
    .roll_angle_o  (roll_angle)
  );

  // Pack result, first field lowest
  assign m_axis_tdata = {{(OUT_DATA_W - OUT_FLD_W){1'b0}},
                         roll_angle, rate_z, rate_y, rate_x, temperature};

endmodule

// ----- rtl/imurcf_ctrl.sv -----
// ----------------------------------------------------------------------------
// imurcf_ctrl
// Sequencer: accepts one sample, steps the CORDIC, schedules the shared
// multiplier and hands the result to the output register.
// ----------------------------------------------------------------------------
module imurcf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output imurcf_pkg::dp_cmd_t cmd_o
);
  import imurcf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RUN,
    S_TILT,
    S_WP,
    S_WT,
    S_ACC,
    S_DONE
  } state_e;

  state_e            state_q;
  logic [STEP_W-1:0] cnt_q;
  logic              out_vld_q;
  logic              out_free;
  logic              accept;

  assign out_free = !out_vld_q || m_axis_tready;
  assign accept   = (state_q == S_IDLE) && s_axis_tvalid;

  // State, step counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      // Drop valid once taken, unless a new result is loaded this cycle
      if (m_axis_tready && (state_q != S_DONE)) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            state_q <= S_RUN;
            cnt_q   <= '0;
          end
        end
        S_RUN: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == STEP_W'(CORDIC_STEPS - 1)) begin
            state_q <= S_TILT;
          end
        end
        S_TILT: state_q <= S_WP;
        S_WP:   state_q <= S_WT;
        S_WT:   state_q <= S_ACC;
        S_ACC:  state_q <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            state_q   <= S_IDLE;
            out_vld_q <= 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_vld_q;

  // Datapath commands; conversions ride on the first CORDIC steps
  always_comb begin
    cmd_o             = '0;
    cmd_o.ld_in       = accept;
    cmd_o.cordic_step = (state_q == S_RUN);
    cmd_o.step_idx    = cnt_q;
    cmd_o.tilt_ld     = (state_q == S_TILT);
    cmd_o.result_ld   = (state_q == S_DONE) && out_free;
    cmd_o.mul_op      = MUL_WT;
    case (state_q)
      S_RUN: begin
        cmd_o.mul_en = (cnt_q <= STEP_W'(MUL_GX));
        cmd_o.mul_op = mul_op_e'(cnt_q[2:0]);
      end
      S_WP: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_WP;
      end
      S_WT: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_WT;
      end
      default: cmd_o.mul_en = 1'b0;
    endcase
  end

endmodule

// ----- rtl/imurcf_dp.sv -----
// ----------------------------------------------------------------------------
// imurcf_dp
// Datapath: sample registers, iterative CORDIC, shared multiplier with
// write-back, blend accumulator, roll state and output registers.
// ----------------------------------------------------------------------------
module imurcf_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [imurcf_pkg::WGT_W-1:0]           cfg_wdata_i,
  input  logic signed [imurcf_pkg::IN_W-1:0]     accel_y_i,
  input  logic signed [imurcf_pkg::IN_W-1:0]     accel_z_i,
  input  logic signed [imurcf_pkg::IN_W-1:0]     temp_raw_i,
  input  logic signed [imurcf_pkg::IN_W-1:0]     gyro_x_i,
  input  logic signed [imurcf_pkg::IN_W-1:0]     gyro_y_i,
  input  logic signed [imurcf_pkg::IN_W-1:0]     gyro_z_i,
  input  imurcf_pkg::dp_cmd_t                    cmd_i,
  output logic signed [imurcf_pkg::TEMP_W-1:0]   temperature_o,
  output logic signed [imurcf_pkg::RATE_W-1:0]   rate_x_o,
  output logic signed [imurcf_pkg::RATE_W-1:0]   rate_y_o,
  output logic signed [imurcf_pkg::RATE_W-1:0]   rate_z_o,
  output logic signed [imurcf_pkg::ROLL_W-1:0]   roll_angle_o
);
  import imurcf_pkg::*;

  function automatic logic [IN_W-1:0] abs16(input logic signed [IN_W-1:0] v);
    return v[IN_W-1] ? IN_W'(-v) : IN_W'(v);
  endfunction

  // Configuration and roll state
  logic [WGT_W-1:0]         weight_q;
  logic signed [ROLL_W-1:0] last_roll_q;

  // Sample registers
  logic signed [IN_W-1:0] tr_q, gx_q, gy_q, gz_q;

  // CORDIC registers
  logic signed [CORD_W-1:0] cx_q, cy_q, ang_q;
  logic                     zero_q;
  logic signed [TILT_W-1:0] tilt_q;

  // Multiplier pipeline
  logic signed [MUL_W-1:0]  opa, opb;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic                     mul_vld_q;
  mul_op_e                  mul_op_q;

  // Working results
  logic signed [TEMP_W-1:0] temp_w_q;
  logic signed [RATE_W-1:0] rx_w_q, ry_w_q, rz_w_q;
  logic signed [PRED_W-1:0] pred_q;
  logic signed [ACC_W-1:0]  acc_q;

  // Output registers
  logic signed [TEMP_W-1:0] temp_o_q;
  logic signed [RATE_W-1:0] rx_o_q, ry_o_q, rz_o_q;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= WEIGHT_RESET;
    end else if (cfg_we_i) begin
      weight_q <= cfg_wdata_i;
    end
  end

  // Capture sample
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      tr_q <= temp_raw_i;
      gx_q <= gyro_x_i;
      gy_q <= gyro_y_i;
      gz_q <= gyro_z_i;
    end
  end

  // CORDIC vectoring: half-turn at load when accel_z is negative, then one micro-rotation per cycle
  logic signed [CORD_W-1:0] y_init, z_init, xs, ys, atan_v;
  assign y_init = CORD_W'(accel_y_i) <<< 8;
  assign z_init = CORD_W'(accel_z_i) <<< 8;
  assign xs     = cx_q >>> cmd_i.step_idx;
  assign ys     = cy_q >>> cmd_i.step_idx;
  assign atan_v = atan_lut(ATAN_IDX_W'(cmd_i.step_idx));

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      zero_q <= (accel_y_i == '0) && (accel_z_i == '0);
      if (accel_z_i[IN_W-1]) begin
        cx_q  <= -z_init;
        cy_q  <= -y_init;
        ang_q <= accel_y_i[IN_W-1] ? -CORD_W'(ANG_HALF_TURN) : CORD_W'(ANG_HALF_TURN);
      end else begin
        cx_q  <= z_init;
        cy_q  <= y_init;
        ang_q <= '0;
      end
    end else if (cmd_i.cordic_step) begin
      if (cy_q[CORD_W-1]) begin
        cx_q  <= cx_q - ys;
        cy_q  <= cy_q + xs;
        ang_q <= ang_q - atan_v;
      end else begin
        cx_q  <= cx_q + ys;
        cy_q  <= cy_q - xs;
        ang_q <= ang_q + atan_v;
      end
    end
  end

  // Round angle to 1/256 degree
  logic signed [CORD_W-1:0] ang_rnd;
  assign ang_rnd = (ang_q + CORD_W'(TILT_ROUND)) >>> TILT_SHIFT;

  always_ff @(posedge clk_i) begin
    if (cmd_i.tilt_ld) begin
      tilt_q <= zero_q ? '0 : TILT_W'(ang_rnd);
    end
  end

  // Operand magnitudes for the rounded constant divisions
  logic signed [TEMP_W-1:0] tn;
  logic [TEMP_W-1:0]        tn_mag;
  logic [MAG_W-1:0]         mag_temp, mag_rx, mag_ry, mag_rz, mag_gx;
  logic [TEMP_W-1:0]        w_comp;

  assign tn       = TEMP_W'(tr_q) + TEMP_W'(TEMP_OFFSET);
  assign tn_mag   = tn[TEMP_W-1] ? TEMP_W'(-tn) : TEMP_W'(tn);
  assign mag_temp = MAG_W'({tn_mag, 6'd0}) + MAG_W'(TEMP_HALF);
  assign mag_rx   = MAG_W'({abs16(gx_q), 7'd0}) + MAG_W'(RATE_HALF);
  assign mag_ry   = MAG_W'({abs16(gy_q), 7'd0}) + MAG_W'(RATE_HALF);
  assign mag_rz   = MAG_W'({abs16(gz_q), 7'd0}) + MAG_W'(RATE_HALF);
  assign mag_gx   = MAG_W'({abs16(gx_q), 6'd0}) + MAG_W'(GX_HALF);
  assign w_comp   = {1'b1, {WGT_W{1'b0}}} - TEMP_W'(weight_q);

  // Select multiplier operands
  always_comb begin
    case (cmd_i.mul_op)
      MUL_TEMP: begin
        opa = $signed({1'b0, mag_temp});
        opb = MUL_W'(TEMP_RECIP);
      end
      MUL_RX: begin
        opa = $signed({1'b0, mag_rx});
        opb = MUL_W'(RATE_RECIP);
      end
      MUL_RY: begin
        opa = $signed({1'b0, mag_ry});
        opb = MUL_W'(RATE_RECIP);
      end
      MUL_RZ: begin
        opa = $signed({1'b0, mag_rz});
        opb = MUL_W'(RATE_RECIP);
      end
      MUL_GX: begin
        opa = $signed({1'b0, mag_gx});
        opb = MUL_W'(GX_RECIP);
      end
      MUL_WP: begin
        opa = MUL_W'(pred_q);
        opb = MUL_W'($signed({1'b0, weight_q}));
      end
      default: begin
        opa = MUL_W'(tilt_q);
        opb = MUL_W'($signed({1'b0, w_comp}));
      end
    endcase
  end

  assign prod_d = opa * opb;

  // Register product and its operation tag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
    end else begin
      mul_vld_q <= cmd_i.mul_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q   <= prod_d;
      mul_op_q <= cmd_i.mul_op;
    end
  end

  // Quotients taken from the product
  logic [TEMP_W-1:0] q_temp;
  logic [RATE_W-1:0] q_rate;
  logic [GXQ_W-1:0]  q_gx;
  assign q_temp = prod_q[TEMP_SHIFT +: TEMP_W];
  assign q_rate = prod_q[RATE_SHIFT +: RATE_W];
  assign q_gx   = prod_q[GX_SHIFT +: GXQ_W];

  // Write back product, restoring sign of the quotients, or accumulate the blend
  always_ff @(posedge clk_i) begin
    if (mul_vld_q) begin
      case (mul_op_q)
        MUL_TEMP: temp_w_q <= tn[TEMP_W-1] ? -$signed(q_temp) : $signed(q_temp);
        MUL_RX:   rx_w_q   <= gx_q[IN_W-1] ? -$signed(q_rate) : $signed(q_rate);
        MUL_RY:   ry_w_q   <= gy_q[IN_W-1] ? -$signed(q_rate) : $signed(q_rate);
        MUL_RZ:   rz_w_q   <= gz_q[IN_W-1] ? -$signed(q_rate) : $signed(q_rate);
        MUL_GX: begin
          if (gx_q[IN_W-1]) begin
            pred_q <= PRED_W'(last_roll_q) - $signed(PRED_W'(q_gx));
          end else begin
            pred_q <= PRED_W'(last_roll_q) + $signed(PRED_W'(q_gx));
          end
        end
        MUL_WP:  acc_q <= ACC_W'(prod_q) + ACC_W'(BLEND_ROUND);
        default: acc_q <= acc_q + ACC_W'(prod_q);
      endcase
    end
  end

  // Scale blend back and saturate
  logic signed [ACC_W-FRAC_W-1:0] roll_full;
  logic signed [ROLL_W-1:0]       roll_sat;
  assign roll_full = acc_q[ACC_W-1:FRAC_W];

  always_comb begin
    if (roll_full > ROLL_LIMIT) begin
      roll_sat = ROLL_W'(ROLL_LIMIT);
    end else if (roll_full < -ROLL_LIMIT) begin
      roll_sat = -ROLL_W'(ROLL_LIMIT);
    end else begin
      roll_sat = ROLL_W'(roll_full);
    end
  end

  // Roll state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_roll_q <= '0;
    end else if (cmd_i.result_ld) begin
      last_roll_q <= roll_sat;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.result_ld) begin
      temp_o_q <= temp_w_q;
      rx_o_q   <= rx_w_q;
      ry_o_q   <= ry_w_q;
      rz_o_q   <= rz_w_q;
    end
  end

  assign temperature_o = temp_o_q;
  assign rate_x_o      = rx_o_q;
  assign rate_y_o      = ry_o_q;
  assign rate_z_o      = rz_o_q;
  assign roll_angle_o  = last_roll_q;

endmodule

// ----- rtl/imurcf_chk.sv -----
// ----------------------------------------------------------------------------
// imurcf_chk
// Port-level checks for the roll complementary filter, bound to the top level.
// ----------------------------------------------------------------------------
module imurcf_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [87:0] m_axis_tdata
);

  // Busy after a transaction: no second sample on the next edge
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after a transaction");

  // No result appears the cycle after a sample is taken
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result appeared too early");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Roll stays within saturation limits
  a_roll_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[82:65]) <= 92160) &&
                      ($signed(m_axis_tdata[82:65]) >= -92160))
    else $error("roll outside saturation range");

endmodule

bind imu_roll_complementary_filter_core imurcf_chk u_imurcf_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- tb/sv/tb_imu_roll_complementary_filter_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_imu_roll_complementary_filter_core
// Self-checking bench for the roll complementary filter. Raw samples are fed
// through the input stream with random gaps. A behavioral filter tracks the
// roll state and the weight to predict each output transaction, and every
// output field is compared in order. Directed corner samples come first,
// then roll saturation, then random samples under several weight settings.
// ----------------------------------------------------------------------------
module tb_imu_roll_complementary_filter_core;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_PRINTS   = 40;
  localparam int RAND_PHASE   = 170;

  // Sample as it sits on the input bus, accel_y in the lowest bits
  typedef struct packed {
    logic signed [15:0] gyro_z;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_x;
    logic signed [15:0] temp_raw;
    logic signed [15:0] accel_z;
    logic signed [15:0] accel_y;
  } imu_sample_t;

  // Output transaction as it sits on the output bus, temperature lowest
  typedef struct packed {
    logic [4:0]         fill;
    logic signed [17:0] roll;
    logic signed [15:0] rate_z;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_x;
    logic signed [16:0] temp;
  } imu_result_t;

  typedef enum int {
    SMP_LEVEL,
    SMP_FULL,
    SMP_NEAR_ZERO,
    SMP_FAST_SPIN
  } sample_kind_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [imurcf_pkg::WGT_W-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [imurcf_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [imurcf_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  // Predictor state
  logic [15:0]         weight_cfg = imurcf_pkg::WEIGHT_RESET;
  longint              roll_state = 0;
  imu_result_t         pending_outputs[$];

  int  err_cnt = 0;
  int  cycle_cnt = 0;
  int  rx_stall = 0;
  bit  tx_idle_en = 1'b1;
  bit  rx_idle_en = 1'b1;

  imu_roll_complementary_filter_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Behavioral filter
  // --------------------------------------------------------------------------
  function automatic longint div_nearest(input longint n, input longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic longint div_floor(input longint n, input longint d);
    if (n >= 0) return n / d;
    return -((-n + d - 1) / d);
  endfunction

  // atan(2^-i) in 1/65536 degree
  function automatic longint atan_step_angle(input int i);
    case (i)
      0:  return 2949120;
      1:  return 1740967;
      2:  return 919879;
      3:  return 466945;
      4:  return 234379;
      5:  return 117304;
      6:  return 58666;
      7:  return 29335;
      8:  return 14668;
      9:  return 7334;
      10: return 3667;
      11: return 1833;
      12: return 917;
      13: return 458;
      14: return 229;
      15: return 115;
      16: return 57;
      17: return 29;
      18: return 14;
      19: return 7;
      20: return 4;
      21: return 2;
      22: return 1;
      default: return 0;
    endcase
  endfunction

  // Vectoring CORDIC, tilt angle in 1/65536 degree
  function automatic longint tilt_angle(input longint acc_y, input longint acc_z);
    longint vx;
    longint vy;
    longint ang;
    longint sx;
    longint sy;
    int     i;
    if (acc_y == 0 && acc_z == 0) return 0;
    vx  = acc_z * 256;
    vy  = acc_y * 256;
    ang = 0;
    // Turn the vector into the right half plane first
    if (acc_z < 0) begin
      ang = (acc_y >= 0) ? longint'(imurcf_pkg::ANG_HALF_TURN)
                         : -longint'(imurcf_pkg::ANG_HALF_TURN);
      vx  = -vx;
      vy  = -vy;
    end
    for (i = 0; i < imurcf_pkg::CORDIC_STEPS && i < 24; i++) begin
      sx = vx >>> i;
      sy = vy >>> i;
      if (vy < 0) begin
        vx  = vx - sy;
        vy  = vy + sx;
        ang = ang - atan_step_angle(i);
      end else begin
        vx  = vx + sy;
        vy  = vy - sx;
        ang = ang + atan_step_angle(i);
      end
    end
    return ang;
  endfunction

  // Predict one output transaction and advance the roll state
  function automatic imu_result_t predict_filter(input imu_sample_t s);
    imu_result_t r;
    longint      wgt;
    longint      pred;
    longint      tilt;
    longint      roll;
    r      = '0;
    wgt    = longint'(weight_cfg);
    r.temp = 17'(div_nearest((longint'($signed(s.temp_raw)) + imurcf_pkg::TEMP_OFFSET) * 64,
                             85));
    r.rate_x = 16'(div_nearest(longint'($signed(s.gyro_x)) * 128, 131));
    r.rate_y = 16'(div_nearest(longint'($signed(s.gyro_y)) * 128, 131));
    r.rate_z = 16'(div_nearest(longint'($signed(s.gyro_z)) * 128, 131));
    pred = roll_state + div_nearest(longint'($signed(s.gyro_x)) * 64, 3275);
    tilt = div_floor(tilt_angle(longint'($signed(s.accel_y)),
                                longint'($signed(s.accel_z))) + 128, 256);
    roll = div_floor(wgt * pred + (65536 - wgt) * tilt + 32768, 65536);
    if (roll > imurcf_pkg::ROLL_LIMIT) roll = longint'(imurcf_pkg::ROLL_LIMIT);
    if (roll < -imurcf_pkg::ROLL_LIMIT) roll = -longint'(imurcf_pkg::ROLL_LIMIT);
    roll_state = roll;
    r.roll = 18'(roll);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Mismatch reporting
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    if (err_cnt < MAX_PRINTS) $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_cnt++;
  endtask

  // --------------------------------------------------------------------------
  // Output side: random backpressure and result check
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rx_stall > 0) begin
      m_axis_tready <= 1'b0;
      rx_stall--;
    end else begin
      m_axis_tready <= rst_ni;
    end
  end

  always @(posedge clk_i) begin : check_results
    imu_result_t got;
    imu_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      rx_stall = rx_idle_en ? $urandom_range(0, 11) : 0;
      if (pending_outputs.size() == 0) begin
        report_mismatch($sformatf("output transaction with nothing pending, data %h",
                                  m_axis_tdata));
      end else begin
        want = pending_outputs.pop_front();
        if (got.temp !== want.temp)
          report_mismatch($sformatf("temperature got %0d want %0d", got.temp, want.temp));
        if (got.rate_x !== want.rate_x)
          report_mismatch($sformatf("rate_x got %0d want %0d", got.rate_x, want.rate_x));
        if (got.rate_y !== want.rate_y)
          report_mismatch($sformatf("rate_y got %0d want %0d", got.rate_y, want.rate_y));
        if (got.rate_z !== want.rate_z)
          report_mismatch($sformatf("rate_z got %0d want %0d", got.rate_z, want.rate_z));
        if (got.roll !== want.roll)
          report_mismatch($sformatf("roll_angle got %0d want %0d", got.roll, want.roll));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // Offer one sample after a random gap, hold until the transaction completes
  task automatic send_sample(input imu_sample_t s);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 11) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= s;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_outputs.push_back(predict_filter(s));
  endtask

  task automatic send_fields(input int ay, input int az, input int tr,
                             input int gx, input int gy, input int gz);
    imu_sample_t s;
    s.accel_y  = 16'(ay);
    s.accel_z  = 16'(az);
    s.temp_raw = 16'(tr);
    s.gyro_x   = 16'(gx);
    s.gyro_y   = 16'(gy);
    s.gyro_z   = 16'(gz);
    send_sample(s);
  endtask

  // Drop valid and wait until every pending output has been taken
  task automatic drain_outputs();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_filter_weight(input logic [15:0] wgt);
    drain_outputs();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= wgt;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    weight_cfg   = wgt;
  endtask

  function automatic imu_sample_t draw_sample(input sample_kind_e kind);
    imu_sample_t s;
    s = {$urandom(), $urandom(), $urandom()};
    case (kind)
      SMP_LEVEL: begin
        s.accel_y  = 16'($urandom_range(0, 40000) - 20000);
        s.accel_z  = 16'($urandom_range(0, 40000) - 20000);
        s.temp_raw = 16'($urandom_range(0, 16000) - 8000);
        s.gyro_x   = 16'($urandom_range(0, 6000) - 3000);
        s.gyro_y   = 16'($urandom_range(0, 6000) - 3000);
        s.gyro_z   = 16'($urandom_range(0, 6000) - 3000);
      end
      SMP_NEAR_ZERO: begin
        s.accel_y = 16'($urandom_range(0, 6) - 3);
        s.accel_z = 16'($urandom_range(0, 6) - 3);
      end
      SMP_FAST_SPIN: begin
        s.gyro_x = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      end
      default: ;
    endcase
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Corner samples under the reset weight
  task automatic test_corner_samples();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    send_fields(0, 0, 0, 0, 0, 0);                        // both accelerations zero
    send_fields(32767, 32767, 32767, 32767, 32767, 32767);
    send_fields(-32768, -32768, -32768, -32768, -32768, -32768);
    send_fields(0, 16384, -12412, 0, 0, 0);               // level, zero degC
    send_fields(0, -16384, 0, 0, 0, 0);                   // upside down, y not negative
    send_fields(-1, -16384, 0, 0, 0, 0);                  // upside down, y negative
    send_fields(16384, 0, 0, 0, 0, 0);
    send_fields(-16384, 0, 0, 0, 0, 0);
    send_fields(32767, -32768, 0, 0, 0, 0);
    send_fields(-32768, -32768, 0, 0, 0, 0);
    send_fields(-32768, 32767, 0, 0, 0, 0);
    send_fields(1, -1, 0, 1, -1, 131);
    send_fields(-1, 1, 0, -65, 65, -131);
    send_fields(0, 0, -12413, 2, -2, 66);
    send_fields(0, -1, 32767, 51, -52, 0);
    send_fields(11585, 11585, -32768, -32768, 32767, 0);
    send_fields(-11585, -11585, 0, 32767, -32768, 0);
    send_fields(0, 0, 0, 0, 0, 0);
  endtask

  // Maximum gyro weight with a full-scale spin, first positive then negative, drives roll into both limits
  task automatic test_roll_saturation();
    imu_sample_t s;
    int          i;
    write_filter_weight(16'hffff);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    for (i = 0; i < 490; i++) begin
      s = draw_sample(SMP_LEVEL);
      s.gyro_x = (i < 170) ? 16'sh7fff : 16'sh8000;
      if (i == 100) begin
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
      end
      send_sample(s);
    end
  endtask

  // Random samples under one weight, idling switched on and off in stretches
  task automatic test_random_samples(input logic [15:0] wgt);
    int           i;
    int           pick;
    sample_kind_e kind;
    write_filter_weight(wgt);
    for (i = 0; i < RAND_PHASE; i++) begin
      if (i % 40 == 0) begin
        tx_idle_en = ($urandom_range(0, 3) != 0);
        rx_idle_en = ($urandom_range(0, 3) != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 60)      kind = SMP_LEVEL;
      else if (pick < 85) kind = SMP_FULL;
      else if (pick < 95) kind = SMP_NEAR_ZERO;
      else                kind = SMP_FAST_SPIN;
      send_sample(draw_sample(kind));
    end
  endtask

  // --------------------------------------------------------------------------
  // Run control
  // --------------------------------------------------------------------------
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Timeout after %0d cycles, %0d outputs pending", cycle_cnt,
             pending_outputs.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_corner_samples();
    test_roll_saturation();
    test_random_samples(16'h0000);
    test_random_samples(16'd64225);
    test_random_samples(16'h0001);
    test_random_samples(16'h8000);
    test_random_samples(16'($urandom()));

    drain_outputs();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
